@@ rtl/sset_pkg.sv @@
// shared constants for the sorted key set: default sizes, opcodes and status codes
// no dependencies; imported by sorted_set_insert_delete_search
package sset_pkg;

    localparam int CAP_DEFAULT = 64;
    localparam int KEY_W_DEFAULT = 16;

    localparam int OP_W = 2;
    localparam int STATUS_W = 2;

    typedef logic [OP_W-1:0] t_opcode;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_opcode OP_INSERT = 2'd0;
    localparam t_opcode OP_DELETE = 2'd1;
    localparam t_opcode OP_SEARCH = 2'd2;

    localparam t_status ST_OK = 2'd0;
    localparam t_status ST_DUP = 2'd1;
    localparam t_status ST_MISSING = 2'd2;
    localparam t_status ST_FULL = 2'd3;

endpackage

@@ rtl/sorted_set_insert_delete_search.sv @@
// sorted key set: ascending distinct signed keys held in one synchronous memory
// depends on sset_pkg for opcodes, status codes and default sizes
//
// Keeps up to CAPACITY distinct signed keys in ascending order in one single-port-read,
// single-port-write memory with a registered read. Each request word (opcode, key) gives
// one result word (status, key, count after the operation). A request is taken only when
// the block is idle, one at a time. Every request first runs a binary search over the
// stored keys, each halving step a memory read and then a compare.
// An insert then moves each larger key up one place and a delete moves each larger key
// down one place, each key moved as a read and then a write through the memory port, plus
// one closing step (the key write for an insert). The fixed steps are accept, end of
// search, decide and result.
// The result register frees the input side: a new request is accepted while the last
// result still waits to be taken. Keys are cleared at reset only by zeroing the count.
module sorted_set_insert_delete_search #(
    parameter int CAPACITY = sset_pkg::CAP_DEFAULT,
    parameter int KEY_WIDTH = sset_pkg::KEY_W_DEFAULT,
    parameter int CNT_W = $clog2(CAPACITY + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  sset_pkg::t_opcode           i_opcode,
    input  logic signed [KEY_WIDTH-1:0] i_value,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output sset_pkg::t_status           o_status,
    output logic signed [KEY_WIDTH-1:0] o_value_echo,
    output logic [CNT_W-1:0]            o_entry_count
);
    import sset_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SRCH_RD = 4'd1;
    localparam logic [3:0] S_SRCH_CMP = 4'd2;
    localparam logic [3:0] S_ACT = 4'd3;
    localparam logic [3:0] S_UP_RD = 4'd4;
    localparam logic [3:0] S_UP_WR = 4'd5;
    localparam logic [3:0] S_DN_RD = 4'd6;
    localparam logic [3:0] S_DN_WR = 4'd7;
    localparam logic [3:0] S_FIN = 4'd8;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic signed [KEY_WIDTH-1:0] r_mem [CAPACITY];
    logic signed [KEY_WIDTH-1:0] r_rd_data;
    logic [AW-1:0]               rd_addr;
    logic                        we;
    logic [AW-1:0]               wr_addr;
    logic signed [KEY_WIDTH-1:0] wr_data;

    logic [3:0]                  r_state, n_state;
    t_opcode                     r_op, n_op;
    logic signed [KEY_WIDTH-1:0] r_key, n_key;
    logic [CNT_W-1:0]            r_count, n_count;
    logic [CNT_W-1:0]            r_lo, n_lo;
    logic [CNT_W-1:0]            r_hi, n_hi;
    logic                        r_hit, n_hit;
    logic [CNT_W-1:0]            r_idx, n_idx;
    t_status                     r_st, n_st;
    logic                        r_o_valid, n_o_valid;
    t_status                     r_o_status, n_o_status;
    logic signed [KEY_WIDTH-1:0] r_o_value, n_o_value;
    logic [CNT_W-1:0]            r_o_count, n_o_count;

    logic [CNT_W:0]              mid_sum;
    logic [CNT_W-1:0]            mid;
    logic [CNT_W-1:0]            idx_dec;
    logic [CNT_W-1:0]            idx_inc;
    logic                        out_free;

    // memory: one read and one write port, registered read data
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid = mid_sum[CNT_W:1];
    assign idx_dec = r_idx - CNT_W'(1);
    assign idx_inc = r_idx + CNT_W'(1);
    assign out_free = !r_o_valid || i_out_ready;

    // a read and a write may touch one entry in the same cycle; such read data is not used
    always_comb begin
        n_state = r_state;
        n_op = r_op;
        n_key = r_key;
        n_count = r_count;
        n_lo = r_lo;
        n_hi = r_hi;
        n_hit = r_hit;
        n_idx = r_idx;
        n_st = r_st;
        n_o_valid = r_o_valid;
        n_o_status = r_o_status;
        n_o_value = r_o_value;
        n_o_count = r_o_count;
        rd_addr = mid[AW-1:0];
        we = 1'b0;
        wr_addr = r_idx[AW-1:0];
        wr_data = r_rd_data;

        if (r_o_valid && i_out_ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op = i_opcode;
                    n_key = i_value;
                    n_lo = '0;
                    n_hi = r_count;
                    n_hit = 1'b0;
                    n_state = S_SRCH_RD;
                end
            end
            S_SRCH_RD: begin
                rd_addr = mid[AW-1:0];
                if (r_lo < r_hi) begin
                    n_state = S_SRCH_CMP;
                end else begin
                    n_state = S_ACT;
                end
            end
            S_SRCH_CMP: begin
                // lower bound: first slot whose key is not below the request
                if (r_rd_data < r_key) begin
                    n_lo = mid + CNT_W'(1);
                end else begin
                    n_hi = mid;
                    n_hit = (r_rd_data == r_key);
                end
                n_state = S_SRCH_RD;
            end
            S_ACT: begin
                n_state = S_FIN;
                case (r_op)
                    OP_INSERT: begin
                        if (r_hit) begin
                            n_st = ST_DUP;
                        end else if (r_count >= CAP_CNT) begin
                            n_st = ST_FULL;
                        end else begin
                            n_idx = r_count;
                            n_state = S_UP_RD;
                        end
                    end
                    OP_DELETE: begin
                        if (r_hit) begin
                            n_idx = r_lo;
                            n_state = S_DN_RD;
                        end else begin
                            n_st = ST_MISSING;
                        end
                    end
                    OP_SEARCH: begin
                        n_st = r_hit ? ST_OK : ST_MISSING;
                    end
                    default: begin
                        n_st = ST_MISSING;
                    end
                endcase
            end
            S_UP_RD: begin
                if (r_idx == r_lo) begin
                    we = 1'b1;
                    wr_addr = r_lo[AW-1:0];
                    wr_data = r_key;
                    n_count = r_count + CNT_W'(1);
                    n_st = ST_OK;
                    n_state = S_FIN;
                end else begin
                    rd_addr = idx_dec[AW-1:0];
                    n_state = S_UP_WR;
                end
            end
            S_UP_WR: begin
                we = 1'b1;
                wr_addr = r_idx[AW-1:0];
                n_idx = idx_dec;
                n_state = S_UP_RD;
            end
            S_DN_RD: begin
                if (idx_inc >= r_count) begin
                    n_count = r_count - CNT_W'(1);
                    n_st = ST_OK;
                    n_state = S_FIN;
                end else begin
                    rd_addr = idx_inc[AW-1:0];
                    n_state = S_DN_WR;
                end
            end
            S_DN_WR: begin
                we = 1'b1;
                wr_addr = r_idx[AW-1:0];
                n_idx = idx_inc;
                n_state = S_DN_RD;
            end
            S_FIN: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_status = r_st;
                    n_o_value = r_key;
                    n_o_count = r_count;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_o_valid <= n_o_valid;
        end
        r_op <= n_op;
        r_key <= n_key;
        r_lo <= n_lo;
        r_hi <= n_hi;
        r_hit <= n_hit;
        r_idx <= n_idx;
        r_st <= n_st;
        r_o_status <= n_o_status;
        r_o_value <= n_o_value;
        r_o_count <= n_o_count;
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_o_valid;
    assign o_status = r_o_status;
    assign o_value_echo = r_o_value;
    assign o_entry_count = r_o_count;

    // the count never passes capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT)
        else $error("key count above capacity");

    // the count moves by one at most per operation, and only from the insert or delete read step
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_count != $past(r_count)) |->
            ($past(r_state) == S_UP_RD || $past(r_state) == S_DN_RD))
        else $error("key count changed outside an update");

    // a result word is only raised from the finish step
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(r_o_valid) |-> $past(r_state) == S_FIN)
        else $error("result raised outside finish");

    // search window stays ordered and within the stored keys
    a_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH_CMP) |-> (r_lo < r_hi) && (r_hi <= r_count))
        else $error("search window out of range");

    // an insert only completes a write when there is room
    a_ins_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP_RD) |-> (r_count < CAP_CNT))
        else $error("insert shift with a full store");

endmodule
